// ----- design/integer_to_ascii_formatter_top_assert.svh -----
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// Implication checked in the same cycle.
`define ITAF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define ITAF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/itaf_pkg.sv -----
// Shared types, constants and helpers for the integer to ASCII formatter.
package itaf_pkg;

  localparam int MaxCharsDef   = 64;
  localparam int ValueWidthDef = 64;

  // Input tdata layout, lowest bit first.
  localparam int InDataW   = 96;
  localparam int RadixLsb  = 64;
  localparam int PrefixBit = 69;
  localparam int MinWLsb   = 70;
  localparam int FillLsb   = 77;
  localparam int SepLsb    = 85;
  localparam int OutDataW  = 8;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharX     = 8'h78;
  localparam logic [7:0] CharMinus = 8'h2d;

  localparam logic [8*31-1:0] DigitTable = "FEDCBA9876543210123456789ABCDEF";

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_ZFILL,
    ST_PX,
    ST_P0,
    ST_SIGN,
    ST_FILL,
    ST_RD,
    ST_WAIT,
    ST_ERR
  } itaf_state_e;

  typedef enum logic [2:0] {
    CH_SEP,
    CH_DIGIT,
    CH_ZERO,
    CH_X,
    CH_MINUS,
    CH_FILL
  } itaf_char_e;

  typedef struct packed {
    logic       load;
    logic       div_en;
    logic       wr_en;
    itaf_char_e wr_sel;
    logic       rd_en;
    logic       out_load;
    logic       out_err;
  } itaf_cmd_t;

  typedef struct packed {
    logic radix_bad;
    logic div_last;
    logic sep_due;
    logic q_zero;
    logic len_full;
    logic zfill_due;
    logic fill_due;
    logic pre8;
    logic pre16;
    logic neg;
    logic emit_last;
    logic out_free;
  } itaf_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] rem);
    logic [4:0] idx;
    idx = 5'd15 - {1'b0, rem};
    return DigitTable[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ----- design/integer_to_ascii_formatter_top.sv -----
// Each digit comes from the 8-bit-per-cycle divider stepping through the value, then a digit write.
// Separators are written during a divider step; fill, prefix and sign go in one character per cycle.
// Emission reads each character from the store, then loads the output register, waiting while it is held.
// One item is in work at a time; a bad radix goes straight to its error transfer.
// Reset (rst_ni low, asynchronous) returns to idle and clears the output valid.
module integer_to_ascii_formatter_top import itaf_pkg::*; #(
  parameter int MAX_CHARS   = MaxCharsDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // value_bits[63:0], radix[68:64], want_prefix[69], min_width[76:70],
  // fill_char[84:77], group_sep[92:85], zero[95:93]
  input  logic [InDataW-1:0] s_axis_tdata,
  // is_signed[0]
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // out_char[7:0]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic               m_axis_tlast,
  // format_error[0]
  output logic               m_axis_tuser
);

  itaf_cmd_t cmd;
  itaf_sts_t sts;

  itaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itaf_dp #(
    .MAX_CHARS   (MAX_CHARS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_signed_i (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

`include "integer_to_ascii_formatter_top_assert.svh"

  `ITAF_ASSERT_IMP(a_err_is_single, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "error transfer must be last with zero char")
  `ITAF_ASSERT_NXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted twice in a row")
  `ITAF_ASSERT_IMP(a_store_bound, clk_i, rst_ni, cmd.wr_en, !sts.len_full, "write beyond text store")

endmodule

// ----- design/itaf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module itaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/itaf_ctrl.sv -----
// Controller state machine: sequences division, padding, prefix, sign and emission.
module itaf_ctrl import itaf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  itaf_sts_t sts_i,
  output itaf_cmd_t cmd_o
);

  itaf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.radix_bad ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts_i.sep_due && sts_i.len_full) begin
          state_d = ST_ERR;
        end else if (sts_i.div_last) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.len_full) begin
          state_d = ST_ERR;
        end else begin
          state_d = sts_i.q_zero ? ST_ZFILL : ST_DIV;
        end
      end
      ST_ZFILL: begin
        if (sts_i.zfill_due) begin
          if (sts_i.len_full) state_d = ST_ERR;
        end else if (sts_i.pre16) begin
          state_d = ST_PX;
        end else if (sts_i.pre8) begin
          state_d = ST_P0;
        end else begin
          state_d = sts_i.neg ? ST_SIGN : ST_FILL;
        end
      end
      ST_PX: begin
        state_d = sts_i.len_full ? ST_ERR : ST_P0;
      end
      ST_P0: begin
        if (sts_i.len_full) begin
          state_d = ST_ERR;
        end else begin
          state_d = sts_i.neg ? ST_SIGN : ST_FILL;
        end
      end
      ST_SIGN: begin
        state_d = sts_i.len_full ? ST_ERR : ST_FILL;
      end
      ST_FILL: begin
        if (sts_i.fill_due) begin
          if (sts_i.len_full) state_d = ST_ERR;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.emit_last ? ST_IDLE : ST_RD;
        end
      end
      ST_ERR: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.div_en = 1'b1;
        // a separator goes in ahead of the digit about to be produced
        if (sts_i.sep_due && !sts_i.len_full) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = CH_SEP;
        end
      end
      ST_DIGIT: begin
        cmd_o.wr_en  = !sts_i.len_full;
        cmd_o.wr_sel = CH_DIGIT;
      end
      ST_ZFILL: begin
        cmd_o.wr_en  = sts_i.zfill_due && !sts_i.len_full;
        cmd_o.wr_sel = CH_ZERO;
      end
      ST_PX: begin
        cmd_o.wr_en  = !sts_i.len_full;
        cmd_o.wr_sel = CH_X;
      end
      ST_P0: begin
        cmd_o.wr_en  = !sts_i.len_full;
        cmd_o.wr_sel = CH_ZERO;
      end
      ST_SIGN: begin
        cmd_o.wr_en  = !sts_i.len_full;
        cmd_o.wr_sel = CH_MINUS;
      end
      ST_FILL: begin
        cmd_o.wr_en  = sts_i.fill_due && !sts_i.len_full;
        cmd_o.wr_sel = CH_FILL;
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_WAIT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      ST_ERR: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_err  = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ----- design/itaf_dp.sv -----
// Datapath: radix divider, text store, length counters and output register.
module itaf_dp import itaf_pkg::*; #(
  parameter int MAX_CHARS   = MaxCharsDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [InDataW-1:0] in_data_i,
  input  logic               in_signed_i,
  input  itaf_cmd_t          cmd_i,
  output itaf_sts_t          sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_char_o,
  output logic               out_last_o,
  output logic               out_err_o
);

  localparam int LenW     = $clog2(MAX_CHARS + 1);
  localparam int AddrW    = $clog2(MAX_CHARS);
  localparam int DivSteps = (VALUE_WIDTH + 7) / 8;
  localparam int QW       = DivSteps * 8;
  localparam int CntW     = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  // input decode
  logic [VALUE_WIDTH-1:0] v_in, mag_in;
  logic [4:0]             radix_in;
  logic [7:0]             sep_in;
  logic                   neg_in, pre_in;

  assign v_in     = in_data_i[VALUE_WIDTH-1:0];
  assign radix_in = in_data_i[RadixLsb +: 5];
  assign pre_in   = in_data_i[PrefixBit];
  assign sep_in   = in_data_i[SepLsb +: 8];
  assign neg_in   = in_signed_i & v_in[VALUE_WIDTH-1];
  assign mag_in   = neg_in ? (~v_in + VALUE_WIDTH'(1)) : v_in;

  // per-item options
  logic [4:0]      radix_q;
  logic            pre8_q, pre16_q, neg_q, sep_en_q;
  logic [6:0]      minw_q;
  logic [7:0]      fill_q, sep_q;
  logic [QW-1:0]   q_q;
  logic [3:0]      r_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      group_q;
  logic [LenW-1:0] len_q, k_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      radix_q  <= radix_in;
      pre8_q   <= pre_in && (radix_in == 5'd8);
      pre16_q  <= pre_in && (radix_in == 5'd16);
      neg_q    <= neg_in;
      minw_q   <= in_data_i[MinWLsb +: 7];
      fill_q   <= in_data_i[FillLsb +: 8];
      sep_q    <= sep_in;
      sep_en_q <= (sep_in != 8'd0) && (radix_in == 5'd10);
    end
  end

  // restoring division, eight quotient bits per cycle
  logic [7:0] chunk, qbits;
  logic [4:0] rem;

  assign chunk = q_q[QW-1 -: 8];

  always_comb begin
    rem   = (cnt_q == '0) ? 5'd0 : {1'b0, r_q};
    qbits = '0;
    for (int i = 7; i >= 0; i--) begin
      rem = {rem[3:0], chunk[i]};
      if (rem >= radix_q) begin
        rem      = rem - radix_q;
        qbits[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q <= QW'(mag_in);
      r_q <= 4'd0;
    end else if (cmd_i.div_en) begin
      q_q <= QW'({q_q, qbits});
      r_q <= rem[3:0];
    end
  end

  // character select and store write
  logic [7:0] wr_char;

  always_comb begin
    case (cmd_i.wr_sel)
      CH_SEP:   wr_char = sep_q;
      CH_DIGIT: wr_char = digit_char(r_q);
      CH_ZERO:  wr_char = CharZero;
      CH_X:     wr_char = CharX;
      CH_MINUS: wr_char = CharMinus;
      CH_FILL:  wr_char = fill_q;
      default:  wr_char = 8'd0;
    endcase
  end

  logic            out_valid_q, out_last_q, out_err_q;
  logic [7:0]      out_char_q;
  logic [7:0]      ram_rdata;
  logic [LenW-1:0] emit_pos;
  logic            emit_last;

  assign emit_pos  = len_q - k_q - LenW'(1);
  assign emit_last = (k_q + LenW'(1)) == len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      group_q <= '0;
      len_q   <= '0;
      k_q     <= '0;
    end else if (cmd_i.load) begin
      cnt_q   <= '0;
      group_q <= '0;
      len_q   <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.div_en) begin
        cnt_q <= (cnt_q == CntW'(DivSteps - 1)) ? '0 : cnt_q + CntW'(1);
      end
      if (cmd_i.wr_en) begin
        len_q <= len_q + LenW'(1);
        if (cmd_i.wr_sel == CH_SEP) begin
          group_q <= '0;
        end else if (cmd_i.wr_sel == CH_DIGIT) begin
          group_q <= group_q + 2'd1;
        end
      end
      if (cmd_i.out_load && !cmd_i.out_err) begin
        k_q <= k_q + LenW'(1);
      end
    end
  end

  itaf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHARS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (len_q[AddrW-1:0]),
    .wdata_i (wr_char),
    .re_i    (cmd_i.rd_en),
    .raddr_i (emit_pos[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q <= cmd_i.out_err ? 8'd0 : ram_rdata;
      out_last_q <= cmd_i.out_err ? 1'b1 : emit_last;
      out_err_q  <= cmd_i.out_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

  // padding targets: zero fill shrinks by sign and prefix length
  logic              zero_mode;
  logic [1:0]        zsub;
  logic signed [8:0] ztarget, len9;

  assign zero_mode = (fill_q == CharZero);
  assign zsub      = {pre16_q, 1'b0} + {1'b0, pre8_q} + {1'b0, neg_q};
  assign ztarget   = $signed({2'b00, minw_q}) - $signed({7'b0, zsub});
  assign len9      = $signed(9'(len_q));

  always_comb begin
    sts_o           = '0;
    sts_o.radix_bad = (radix_in < 5'd2) || (radix_in > 5'd16);
    sts_o.div_last  = (cnt_q == CntW'(DivSteps - 1));
    sts_o.sep_due   = (cnt_q == '0) && (group_q == 2'd3) && sep_en_q;
    sts_o.q_zero    = (q_q == '0);
    sts_o.len_full  = (len_q == LenW'(MAX_CHARS));
    sts_o.zfill_due = zero_mode && (len9 < ztarget);
    sts_o.fill_due  = !zero_mode && (8'(len_q) < {1'b0, minw_q});
    sts_o.pre8      = pre8_q;
    sts_o.pre16     = pre16_q;
    sts_o.neg       = neg_q;
    sts_o.emit_last = emit_last;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

// ----- verif/integer_to_ascii_formatter_checker.sv -----
// Checker for the integer to ASCII formatter: predicts the text of each item and compares it.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_checker import itaf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  logic                in_user_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [OutDataW-1:0] out_data_i,
  input  logic                out_last_i,
  input  logic                out_user_i,
  output int                  mismatches_o,
  output int                  chars_pending_o
);

  localparam int         TextMax    = MaxCharsDef;
  localparam logic [7:0] CharUpperA = 8'h41;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } text_char_t;

  text_char_t chars_expected[$];
  int         mismatch_count = 0;
  int         pending_count  = 0;

  assign mismatches_o    = mismatch_count;
  assign chars_pending_o = pending_count;

  function automatic logic [7:0] digit_ascii(input logic [3:0] r);
    if (r < 4'd10) return CharZero + {4'h0, r};
    return CharUpperA + {4'h0, r} - 8'd10;
  endfunction

  // Append one character; a full buffer flags overflow instead.
  function automatic void append_char(inout logic [7:0] txt [TextMax], inout int len,
                                      inout bit overflow, input logic [7:0] c);
    if (len >= TextMax) begin
      overflow = 1'b1;
    end else begin
      txt[len] = c;
      len++;
    end
  endfunction

  // Build the text least significant character first; -1 means an error result.
  function automatic int render_text(input logic [63:0] raw, input logic sgn,
                                     input logic [4:0] base, input logic pre,
                                     input logic [6:0] mw, input logic [7:0] fill,
                                     input logic [7:0] sep, output logic [7:0] txt [TextMax]);
    logic [63:0] q;
    logic [63:0] r;
    logic        neg;
    logic        pre8;
    logic        pre16;
    bit          overflow;
    int          len;
    int          width;
    int          group;
    txt = '{default: 8'h00};
    if (base < 5'd2 || base > 5'd16) return -1;
    neg      = sgn & raw[63];
    q        = neg ? -raw : raw;
    pre8     = pre && base == 5'd8;
    pre16    = pre && base == 5'd16;
    overflow = 1'b0;
    len      = 0;
    group    = 0;
    width    = int'(mw);
    do begin
      if (sep != 8'h00 && base == 5'd10 && group == 3) begin
        append_char(txt, len, overflow, sep);
        group = 0;
      end
      r = q % {59'd0, base};
      q = q / {59'd0, base};
      append_char(txt, len, overflow, digit_ascii(r[3:0]));
      group++;
    end while (q != 64'd0 && !overflow);
    // Zero fill sits between the digits and the prefix and sign.
    if (fill == CharZero) begin
      if (neg) width--;
      if (pre8) width--;
      if (pre16) width -= 2;
      while (!overflow && len < width) append_char(txt, len, overflow, fill);
    end
    if (pre8) begin
      append_char(txt, len, overflow, CharZero);
    end else if (pre16) begin
      append_char(txt, len, overflow, CharX);
      append_char(txt, len, overflow, CharZero);
    end
    if (neg) append_char(txt, len, overflow, CharMinus);
    if (fill != CharZero) begin
      while (!overflow && len < width) append_char(txt, len, overflow, fill);
    end
    return overflow ? -1 : len;
  endfunction

  always @(posedge clk_i) begin : track
    logic [7:0] txt [TextMax];
    int         n;
    text_char_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        n = render_text(in_data_i[63:0], in_user_i, in_data_i[RadixLsb +: 5],
                        in_data_i[PrefixBit], in_data_i[MinWLsb +: 7],
                        in_data_i[FillLsb +: 8], in_data_i[SepLsb +: 8], txt);
        if (n < 0) begin
          chars_expected.push_back('{ch: 8'h00, last: 1'b1, err: 1'b1});
        end else begin
          for (int k = 0; k < n; k++) begin
            chars_expected.push_back('{ch: txt[n-1-k], last: (k == n-1), err: 1'b0});
          end
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (chars_expected.size() == 0) begin
          $display("%0t: unexpected transfer, got char %02h last %0b error %0b",
                   $time, out_data_i, out_last_i, out_user_i);
          mismatch_count++;
        end else begin
          want = chars_expected.pop_front();
          if (out_data_i !== want.ch) begin
            $display("%0t: out_char expected %02h, got %02h", $time, want.ch, out_data_i);
            mismatch_count++;
          end
          if (out_last_i !== want.last) begin
            $display("%0t: last_char expected %0b, got %0b", $time, want.last, out_last_i);
            mismatch_count++;
          end
          if (out_user_i !== want.err) begin
            $display("%0t: format_error expected %0b, got %0b", $time, want.err, out_user_i);
            mismatch_count++;
          end
        end
      end
      pending_count = chars_expected.size();
    end
  end

endmodule

// ----- verif/tb_integer_to_ascii_formatter_top.sv -----
// Testbench top for the integer to ASCII formatter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter_top;
  import itaf_pkg::*;

  localparam logic [7:0] FillSpace  = 8'h20;
  localparam logic [7:0] FillStar   = 8'h2a;
  localparam logic [7:0] SepComma   = 8'h2c;
  localparam logic [7:0] SepUnder   = 8'h5f;
  localparam logic [63:0] MostNeg   = 64'h8000_0000_0000_0000;
  localparam int         RandomItems = 255;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                m_axis_tuser;
  int                  mismatches;
  int                  chars_pending;
  bit                  tx_fast;

  integer_to_ascii_formatter_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  integer_to_ascii_formatter_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .in_user_i       (s_axis_tuser),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_last_i      (m_axis_tlast),
    .out_user_i      (m_axis_tuser),
    .mismatches_o    (mismatches),
    .chars_pending_o (chars_pending)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Offer one item after a random gap and hold it until the transfer.
  task automatic send_item(input logic [63:0] value, input logic sgn, input logic [4:0] radix,
                           input logic pre, input logic [6:0] mw, input logic [7:0] fill,
                           input logic [7:0] sep);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 15) == 0) tx_fast = !tx_fast;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, sep, fill, mw, pre, radix, value};
    s_axis_tuser  <= sgn;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  task automatic send_random();
    logic [63:0] value;
    logic [4:0]  radix;
    logic [6:0]  mw;
    logic [7:0]  fill;
    logic [7:0]  sep;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) radix = 5'($urandom_range(0, 31));
    else if (pick < 45) radix = 5'd10;
    else if (pick < 65) radix = 5'd16;
    else if (pick < 73) radix = 5'd8;
    else if (pick < 78) radix = 5'd2;
    else radix = 5'($urandom_range(2, 16));
    case ($urandom_range(0, 4))
      0: value = 64'($urandom_range(0, 9999));
      1: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: value = 64'd0 - 64'($urandom_range(1, 99999));
      default: value = {$urandom, $urandom};
    endcase
    mw = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 24));
    case ($urandom_range(0, 2))
      0: fill = CharZero;
      1: fill = FillSpace;
      default: fill = 8'($urandom_range(0, 255));
    endcase
    if ($urandom_range(0, 1) == 0) sep = 8'h00;
    else sep = ($urandom_range(0, 1) == 0) ? SepComma : 8'($urandom_range(0, 255));
    send_item(value, 1'($urandom_range(0, 1)), radix, 1'($urandom_range(0, 1)), mw, fill, sep);
  endtask

  // Drop valid and hold until every predicted character has come out.
  task automatic drain_text();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (chars_pending != 0);
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_ni        = 1'b0;
    tx_fast       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(64'd0, 1'b0, 5'd10, 1'b0, 7'd0, FillSpace, 8'h00);
    send_item('1, 1'b0, 5'd10, 1'b0, 7'd0, FillSpace, SepComma);
    send_item('1, 1'b1, 5'd10, 1'b0, 7'd0, FillSpace, SepComma);
    send_item(MostNeg, 1'b1, 5'd10, 1'b0, 7'd0, FillSpace, SepComma);
    // sign plus 64 binary digits overflows the buffer
    send_item(MostNeg, 1'b1, 5'd2, 1'b0, 7'd0, FillSpace, 8'h00);
    send_item('1, 1'b0, 5'd2, 1'b1, 7'd0, CharZero, 8'h00);
    send_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 5'd16, 1'b1, 7'd20, CharZero, 8'h00);
    send_item(64'hFFFF_FFFF_FFFF_EDCC, 1'b1, 5'd16, 1'b1, 7'd30, FillSpace, SepComma);
    send_item(64'hFFFF_FFFF_FFFF_FFF8, 1'b1, 5'd8, 1'b1, 7'd12, CharZero, 8'h00);
    send_item(64'd42, 1'b0, 5'd0, 1'b0, 7'd0, FillSpace, 8'h00);
    send_item(64'd42, 1'b0, 5'd1, 1'b0, 7'd0, FillSpace, 8'h00);
    send_item(64'd42, 1'b0, 5'd17, 1'b0, 7'd0, FillSpace, 8'h00);
    send_item('1, 1'b1, 5'd31, 1'b1, 7'd127, 8'hFF, 8'hFF);
    send_item(64'd5, 1'b0, 5'd10, 1'b0, 7'd64, FillStar, 8'h00);
    send_item(64'd5, 1'b0, 5'd10, 1'b0, 7'd65, FillStar, 8'h00);
    send_item(64'd5, 1'b1, 5'd10, 1'b0, 7'd127, CharZero, 8'h00);
    send_item(64'd1000, 1'b0, 5'd10, 1'b0, 7'd0, FillSpace, SepUnder);
    send_item(64'd999, 1'b0, 5'd10, 1'b0, 7'd0, FillSpace, SepUnder);
    send_item(64'd123456, 1'b0, 5'd10, 1'b0, 7'd10, CharZero, SepComma);
    send_item(64'h0123_4567_89AB_CDEF, 1'b0, 5'd16, 1'b0, 7'd0, 8'h00, 8'h00);
    send_item(64'd0, 1'b0, 5'd8, 1'b0, 7'd5, 8'h00, 8'h00);
    send_item(64'd100, 1'b0, 5'd3, 1'b0, 7'd0, FillSpace, 8'h00);
    send_item(64'd12345, 1'b1, 5'd7, 1'b1, 7'd8, 8'hFF, SepComma);
    send_item(64'hFFFF_FFFF_FFFF_FF85, 1'b1, 5'd10, 1'b1, 7'd6, FillSpace, SepComma);
    send_item(64'd0, 1'b1, 5'd16, 1'b1, 7'd0, CharZero, 8'h00);
    drain_text();

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems / 2) drain_text();
      send_random();
    end
    drain_text();
    repeat (200) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb_integer_to_ascii_formatter_top: done, clean");
    end else begin
      $display("tb_integer_to_ascii_formatter_top: done, errors");
    end
    $finish;
  end

  // Output side: random stalls, plus one long hold-off that backs up the input.
  initial begin : sink
    int stall;
    int taken;
    bit rx_fast;
    m_axis_tready = 1'b0;
    taken         = 0;
    rx_fast       = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (taken == 600) stall = 1500;
      else stall = rx_fast ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 39) == 0) rx_fast = !rx_fast;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    #(24_000_000);
    $display("tb_integer_to_ascii_formatter_top: done, errors");
    $finish;
  end

endmodule

// ----- integer_to_ascii_formatter_top.f -----
+incdir+design
design/itaf_pkg.sv
design/itaf_ram.sv
design/itaf_ctrl.sv
design/itaf_dp.sv
design/integer_to_ascii_formatter_top.sv
verif/integer_to_ascii_formatter_checker.sv
verif/tb_integer_to_ascii_formatter_top.sv
